FILE: rtl/labeled_nearest_point_search_core_defines.svh
// Assertion macros shared by the checker.
`ifndef LABELED_NEAREST_POINT_SEARCH_CORE_DEFINES_SVH
`define LABELED_NEAREST_POINT_SEARCH_CORE_DEFINES_SVH

// Consequent checked on the same edge.
`define LNPS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked on the next edge.
`define LNPS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/lnps_pkg.sv
`timescale 1ns / 1ps
package lnps_pkg;

  localparam int MAX_POINTS_DEF = 1024;
  localparam int COORD_BITS_DEF = 24;
  localparam int GAIN_W = 24;
  localparam int TIME_W = 16;
  localparam int LABEL_W = 8;
  localparam int DIST_W = 50;
  localparam int FORCE_W = 32;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 24'd1678;

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_CLEAR = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_NONE = 2'd2;

  typedef struct packed {
    logic       capture;
    logic       clear;
    logic       load_wr;
    logic       scan;
    logic       frc_dif;
    logic       frc_mul;
    logic       frc_fin;
    logic [1:0] axis;
    logic       out_load;
  } lnps_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       scan_more;
    logic       pipe_busy;
    logic       found;
    logic       out_free;
  } lnps_stat_t;

endpackage

FILE: rtl/lnps_ram.sv
`timescale 1ns / 1ps
module lnps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/lnps_ctrl.sv
`timescale 1ns / 1ps
module lnps_ctrl import lnps_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  lnps_stat_t stat,
  output lnps_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_LOAD, S_SCAN, S_DRAIN, S_FDIF, S_FMUL, S_FFIN, S_REPLY
  } state_t;

  state_t     state_r;
  logic [1:0] axis_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      axis_r  <= 2'd0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_valid) state_r <= S_DECODE;
        end
        S_DECODE: begin
          case (stat.cmd)
            CMD_LOAD:  state_r <= S_LOAD;
            CMD_QUERY: state_r <= S_SCAN;
            default:   state_r <= S_REPLY;
          endcase
        end
        S_LOAD: state_r <= S_REPLY;
        S_SCAN: begin
          if (!stat.scan_more) state_r <= S_DRAIN;
        end
        S_DRAIN: begin
          if (!stat.pipe_busy) begin
            axis_r  <= 2'd0;
            state_r <= stat.found ? S_FDIF : S_REPLY;
          end
        end
        S_FDIF: state_r <= S_FMUL;
        S_FMUL: state_r <= S_FFIN;
        S_FFIN: begin
          if (axis_r == 2'd2) begin
            state_r <= S_REPLY;
          end else begin
            axis_r  <= axis_r + 2'd1;
            state_r <= S_FDIF;
          end
        end
        S_REPLY: begin
          if (stat.out_free) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd          = '0;
    cmd.capture  = (state_r == S_IDLE) && in_valid;
    cmd.clear    = (state_r == S_DECODE) && (stat.cmd == CMD_CLEAR);
    cmd.load_wr  = (state_r == S_LOAD);
    cmd.scan     = (state_r == S_SCAN);
    cmd.frc_dif  = (state_r == S_FDIF);
    cmd.frc_mul  = (state_r == S_FMUL);
    cmd.frc_fin  = (state_r == S_FFIN);
    cmd.axis     = axis_r;
    cmd.out_load = (state_r == S_REPLY) && stat.out_free;
  end

endmodule

FILE: rtl/lnps_datapath.sv
`timescale 1ns / 1ps
module lnps_datapath import lnps_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [1:0]                   in_command,
  input  logic [LABEL_W-1:0]           in_label,
  input  logic signed [COORD_BITS-1:0] in_coord_x,
  input  logic signed [COORD_BITS-1:0] in_coord_y,
  input  logic signed [COORD_BITS-1:0] in_coord_z,
  input  logic [TIME_W-1:0]            in_elapsed_time,
  input  logic                         cfg_wr_en,
  input  logic [GAIN_W-1:0]            cfg_wr_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   out_status,
  output logic signed [COORD_BITS-1:0] out_nearest_x,
  output logic signed [COORD_BITS-1:0] out_nearest_y,
  output logic signed [COORD_BITS-1:0] out_nearest_z,
  output logic [DIST_W-1:0]            out_distance_squared,
  output logic signed [FORCE_W-1:0]    out_force_x,
  output logic signed [FORCE_W-1:0]    out_force_y,
  output logic signed [FORCE_W-1:0]    out_force_z,
  input  lnps_cmd_t                    cmd,
  output lnps_stat_t                   stat
);

  localparam int CB    = COORD_BITS;
  localparam int AW    = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int WORD  = LABEL_W + 3 * CB;
  localparam int MW    = CB + 1;
  localparam int QW    = MW + 9;
  localparam int GP_W  = GAIN_W + TIME_W;
  localparam logic [63:0] SQ_LIM   = 64'h8000_0000;
  localparam logic [62:0] SQ_CAP   = 63'h4000_0000_0000_0000;
  localparam logic [63:0] DIST_MAX = (64'd1 << DIST_W) - 64'd1;
  localparam logic [63:0] POS_MAX  = 64'h7FFF_FFFF;
  localparam logic [63:0] NEG_MAX  = 64'h8000_0000;

  // captured item
  logic [1:0]          cmd_r;
  logic [LABEL_W-1:0]  lab_r;
  logic signed [CB-1:0] src_x_r, src_y_r, src_z_r;
  logic [GP_W-1:0]     gain_prod_r;
  logic [GAIN_W-1:0]   gain_r;
  logic [CNT_W-1:0]    count_r;
  logic                full_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= GAIN_RESET;
    end else if (cfg_wr_en) begin
      gain_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r       <= in_command;
      lab_r       <= in_label;
      src_x_r     <= in_coord_x;
      src_y_r     <= in_coord_y;
      src_z_r     <= in_coord_z;
      gain_prod_r <= in_elapsed_time * gain_r;
    end
  end

  logic store_full;
  assign store_full = (count_r == CNT_W'(MAX_POINTS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      full_r  <= 1'b0;
    end else begin
      if (cmd.capture) full_r <= 1'b0;
      if (cmd.clear) begin
        count_r <= '0;
      end else if (cmd.load_wr) begin
        if (store_full) full_r <= 1'b1;
        else count_r <= count_r + CNT_W'(1);
      end
    end
  end

  // point store and scan
  logic [CNT_W-1:0] scan_addr_r;
  logic             scan_more, issue;
  logic [WORD-1:0]  rdata;

  assign scan_more = (scan_addr_r < count_r);
  assign issue     = cmd.scan && scan_more;

  lnps_ram #(.WIDTH(WORD), .DEPTH(MAX_POINTS)) u_ram (
    .clk   (clk),
    .we    (cmd.load_wr && !store_full),
    .waddr (count_r[AW-1:0]),
    .wdata ({lab_r, src_x_r, src_y_r, src_z_r}),
    .raddr (scan_addr_r[AW-1:0]),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.capture) scan_addr_r <= '0;
    else if (issue) scan_addr_r <= scan_addr_r + CNT_W'(1);
  end

  logic [LABEL_W-1:0]   rd_lab;
  logic signed [CB-1:0] rd_x, rd_y, rd_z;
  assign {rd_lab, rd_x, rd_y, rd_z} = rdata;

  logic signed [CB:0] dx, dy, dz;
  assign dx = {rd_x[CB-1], rd_x} - {src_x_r[CB-1], src_x_r};
  assign dy = {rd_y[CB-1], rd_y} - {src_y_r[CB-1], src_y_r};
  assign dz = {rd_z[CB-1], rd_z} - {src_z_r[CB-1], src_z_r};

  function automatic logic [MW-1:0] mag_of(input logic signed [CB:0] d);
    return d[CB] ? MW'(-d) : MW'(d);
  endfunction

  function automatic logic [62:0] sq_of(input logic [MW-1:0] m);
    logic [63:0] m64;
    logic [31:0] op;
    logic [63:0] prod;
    m64  = 64'(m);
    op   = m64[31:0];
    prod = op * op;
    return (m64 > SQ_LIM) ? SQ_CAP : prod[62:0];
  endfunction

  logic v1_r, v2_r, v3_r, v4_r;
  logic [MW-1:0]        mx2_r, my2_r, mz2_r;
  logic signed [CB-1:0] x2_r, y2_r, z2_r, x3_r, y3_r, z3_r, x4_r, y4_r, z4_r;
  logic [62:0]          sx3_r, sy3_r, sz3_r;
  logic [63:0]          sum4_r;
  logic                 found_r;
  logic [63:0]          best_d_r;
  logic signed [CB-1:0] best_x_r, best_y_r, best_z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= issue;
      v2_r <= v1_r && (rd_lab == lab_r);
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    mx2_r  <= mag_of(dx);
    my2_r  <= mag_of(dy);
    mz2_r  <= mag_of(dz);
    x2_r   <= rd_x;
    y2_r   <= rd_y;
    z2_r   <= rd_z;
    sx3_r  <= sq_of(mx2_r);
    sy3_r  <= sq_of(my2_r);
    sz3_r  <= sq_of(mz2_r);
    x3_r   <= x2_r;
    y3_r   <= y2_r;
    z3_r   <= z2_r;
    sum4_r <= 64'(sx3_r) + 64'(sy3_r) + 64'(sz3_r);
    x4_r   <= x3_r;
    y4_r   <= y3_r;
    z4_r   <= z3_r;
  end

  // strict less-than keeps the earliest point on a tie
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      found_r <= 1'b0;
    end else if (v4_r && (!found_r || sum4_r < best_d_r)) begin
      found_r  <= 1'b1;
      best_d_r <= sum4_r;
      best_x_r <= x4_r;
      best_y_r <= y4_r;
      best_z_r <= z4_r;
    end
  end

  // force tail, one axis at a time
  logic signed [CB-1:0] near_sel, src_sel;
  logic signed [CB:0]   fd;
  logic [MW-1:0]        fm_r;
  logic                 fpos_r;
  logic [MW+31:0]       p1_r;
  logic [MW+7:0]        p2_r;
  logic [QW-1:0]        q;
  logic [63:0]          q64, qs;
  logic [FORCE_W-1:0]   fres;
  logic signed [FORCE_W-1:0] fx_r, fy_r, fz_r;

  always_comb begin
    case (cmd.axis)
      2'd0:    begin near_sel = best_x_r; src_sel = src_x_r; end
      2'd1:    begin near_sel = best_y_r; src_sel = src_y_r; end
      default: begin near_sel = best_z_r; src_sel = src_z_r; end
    endcase
  end

  assign fd  = {near_sel[CB-1], near_sel} - {src_sel[CB-1], src_sel};
  assign q   = QW'(p2_r) + QW'(p1_r >> 32);
  assign q64 = 64'(q);

  always_comb begin
    if (fpos_r) begin
      qs   = (q64 > NEG_MAX) ? NEG_MAX : q64;
      fres = FORCE_W'(64'd0 - qs);
    end else begin
      qs   = (q64 > POS_MAX) ? POS_MAX : q64;
      fres = FORCE_W'(qs);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.frc_dif) begin
      fm_r   <= mag_of(fd);
      fpos_r <= !fd[CB] && (fd != '0);
    end
    if (cmd.frc_mul) begin
      p1_r <= fm_r * gain_prod_r[31:0];
      p2_r <= fm_r * gain_prod_r[GP_W-1:32];
    end
    if (cmd.frc_fin) begin
      case (cmd.axis)
        2'd0:    fx_r <= fres;
        2'd1:    fy_r <= fres;
        default: fz_r <= fres;
      endcase
    end
  end

  // result register
  logic out_valid_r;
  logic ok_query;
  assign ok_query = (cmd_r == CMD_QUERY) && found_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (cmd_r == CMD_LOAD) out_status <= full_r ? ST_FULL : ST_OK;
      else if (cmd_r == CMD_QUERY && !found_r) out_status <= ST_NONE;
      else out_status <= ST_OK;
      out_nearest_x <= ok_query ? best_x_r : '0;
      out_nearest_y <= ok_query ? best_y_r : '0;
      out_nearest_z <= ok_query ? best_z_r : '0;
      out_distance_squared <= !ok_query ? '0 :
        (best_d_r > DIST_MAX) ? DIST_MAX[DIST_W-1:0] : best_d_r[DIST_W-1:0];
      out_force_x <= ok_query ? fx_r : '0;
      out_force_y <= ok_query ? fy_r : '0;
      out_force_z <= ok_query ? fz_r : '0;
    end
  end

  assign out_valid = out_valid_r;

  always_comb begin
    stat.cmd       = cmd_r;
    stat.scan_more = scan_more;
    stat.pipe_busy = v1_r || v2_r || v3_r || v4_r;
    stat.found     = found_r;
    stat.out_free  = !out_valid_r || out_ready;
  end

endmodule

FILE: rtl/labeled_nearest_point_search_core.sv
`timescale 1ns / 1ps
// Labeled nearest-point search core.
// Input channel (in_valid/in_ready) carries one command per transfer:
// load appends a labeled point, clear empties the store, query searches the
// store for the nearest point with the query's label and returns it with the
// squared distance and the regularization force.
// Output channel (out_valid/out_ready) returns one result per command.
// cfg_wr_en/cfg_wr_data write the force gain; write only while idle.
// A load passes the decode, load and reply states; clear and unused codes go
// from decode to reply. A query scans the stored points, one point per cycle
// from the simple dual-port point memory, then the distance pipeline drains
// and the force logic, reused per axis, computes the three force axes in turn
// via difference, multiply and finish steps. One item is processed at a time.
// The result sits in an output register; a new command is accepted while it
// waits, and the next result is held back until out_ready takes the first.
// Reset empties the store and sets the gain to its default; no clearing
// pass is needed.
module labeled_nearest_point_search_core import lnps_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   in_command,
  input  logic [LABEL_W-1:0]           in_label,
  input  logic signed [COORD_BITS-1:0] in_coord_x,
  input  logic signed [COORD_BITS-1:0] in_coord_y,
  input  logic signed [COORD_BITS-1:0] in_coord_z,
  input  logic [TIME_W-1:0]            in_elapsed_time,
  input  logic                         cfg_wr_en,
  input  logic [GAIN_W-1:0]            cfg_wr_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   out_status,
  output logic signed [COORD_BITS-1:0] out_nearest_x,
  output logic signed [COORD_BITS-1:0] out_nearest_y,
  output logic signed [COORD_BITS-1:0] out_nearest_z,
  output logic [DIST_W-1:0]            out_distance_squared,
  output logic signed [FORCE_W-1:0]    out_force_x,
  output logic signed [FORCE_W-1:0]    out_force_y,
  output logic signed [FORCE_W-1:0]    out_force_z
);

  lnps_cmd_t  cmd;
  lnps_stat_t stat;

  lnps_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lnps_datapath #(.MAX_POINTS(MAX_POINTS), .COORD_BITS(COORD_BITS)) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_command           (in_command),
    .in_label             (in_label),
    .in_coord_x           (in_coord_x),
    .in_coord_y           (in_coord_y),
    .in_coord_z           (in_coord_z),
    .in_elapsed_time      (in_elapsed_time),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_wr_data          (cfg_wr_data),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_status           (out_status),
    .out_nearest_x        (out_nearest_x),
    .out_nearest_y        (out_nearest_y),
    .out_nearest_z        (out_nearest_z),
    .out_distance_squared (out_distance_squared),
    .out_force_x          (out_force_x),
    .out_force_y          (out_force_y),
    .out_force_z          (out_force_z),
    .cmd                  (cmd),
    .stat                 (stat)
  );

endmodule

FILE: rtl/lnps_checker.sv
`timescale 1ns / 1ps
`include "labeled_nearest_point_search_core_defines.svh"
module lnps_checker import lnps_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [1:0]        out_status,
  input logic [DIST_W-1:0] out_distance_squared,
  input logic [FORCE_W-1:0] out_force_x
);

  `LNPS_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `LNPS_ASSERT_NXT(a_stat_hold, out_valid && !out_ready, $stable(out_status), "status changed while stalled")
  `LNPS_ASSERT_NXT(a_busy_after_in, in_valid && in_ready, !in_ready, "ready right after a transfer")
  `LNPS_ASSERT_NOW(a_none_zero, out_valid && out_status == ST_NONE, out_distance_squared == '0 && out_force_x == '0, "nonzero fields without a match")

endmodule

bind labeled_nearest_point_search_core lnps_checker u_chk (.*);
